// ===== hdl/svpwm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the space-vector PWM duty generator.
// Used by svpwm_vf_duty_generator_unit; depends on nothing else.
package svpwm_pkg;

  // Input item commands
  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_TABLE_WR = 1'b1;

  // Configuration register indexes (byte address 4*i)
  localparam logic [1:0] REG_PWM_PERIOD  = 2'd0;
  localparam logic [1:0] REG_MIN_MOD     = 2'd1;
  localparam logic [1:0] REG_SLEW_LIMIT  = 2'd2;
  localparam logic [1:0] REG_PERIOD_NUM  = 2'd3;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Field and state widths
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned TIDX_W   = 10;
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned SEC_W    = 3;
  localparam int unsigned SLEW_W   = 9;
  localparam int unsigned LIM_W    = 8;
  localparam int unsigned MOD_W    = 13;
  localparam int unsigned PER_W    = 22;
  localparam int unsigned POS_W    = 20;

  // Shared multiplier and serial divider
  localparam int unsigned MUL_A_W = 22;
  localparam int unsigned MUL_B_W = 20;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DIV_W   = 42;
  localparam int unsigned DEN_W   = 23;
  localparam int unsigned CNT_W   = 6;

  // Reset values
  localparam logic [WORD_W-1:0] PWM_PERIOD_RST = 16'd2999;
  localparam logic [MOD_W-1:0]  MIN_MOD_RST    = 13'd322;
  localparam logic [LIM_W-1:0]  SLEW_LIMIT_RST = 8'd43;
  localparam logic [PER_W-1:0]  PERIOD_NUM_RST = 22'd3276800;
  localparam logic [MOD_W-1:0]  MOD_INDEX_RST  = 13'd4096;
  localparam logic [PER_W-1:0]  SAMPLES_RST    = 22'd24000;
  localparam logic [SEC_W-1:0]  LAST_SECTOR    = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMUL,
    ST_ADIV_LD,
    ST_ADIV,
    ST_ACLAMP,
    ST_RD_TA,
    ST_RD_TB,
    ST_SCALE_TA,
    ST_SCALE_TB,
    ST_DUTY,
    ST_RC,
    ST_PDIV,
    ST_PSTORE,
    ST_SMUL,
    ST_SDIV,
    ST_SSTORE
  } svpwm_state_e;

endpackage

// ===== hdl/svpwm_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module svpwm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 800
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/svpwm_vf_duty_generator_unit.sv =====
`timescale 1ns / 1ps
// Top level of the space-vector PWM duty generator with V/f speed control.
// Depends on svpwm_pkg and svpwm_ram.
//
// A table-write item (cmd 1) stores one word of the 60-degree sine table. A
// tick item (cmd 0) steps the speed follower, then runs a small sequencer
// around one shared 22x20 multiplier and one radix-2 serial divider:
// angle = round(6*TABLE_DEPTH*pos / P), two table reads, two scalings by the
// modulation index, and the three compare values. When the follower does not
// step, the block takes the next item once the result is written. When it
// steps, one or two more divisions follow (samples per period, then the
// rescaled position if the old period is nonzero). in_stall_o is high for
// the whole sequence. The result sits in an output register, so new items are
// taken while it waits; a later tick holds in its duty step until the previous
// result is gone. The sine table is undefined until written and must be loaded
// before ticks are sent.
module svpwm_vf_duty_generator_unit #(
  parameter int unsigned TABLE_DEPTH = 800
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input items
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              cmd_i,
  input  logic [svpwm_pkg::SAMPLE_W-1:0]    adc_sample_i,
  input  logic [svpwm_pkg::TIDX_W-1:0]      table_index_i,
  input  logic [svpwm_pkg::WORD_W-1:0]      table_value_i,
  // result items
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [svpwm_pkg::WORD_W-1:0]      duty_a_o,
  output logic [svpwm_pkg::WORD_W-1:0]      duty_b_o,
  output logic [svpwm_pkg::WORD_W-1:0]      duty_c_o,
  output logic [svpwm_pkg::SEC_W-1:0]       sector_used_o,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [svpwm_pkg::PADDR_W-1:0]     paddr,
  input  logic [svpwm_pkg::PDATA_W-1:0]     pwdata,
  output logic [svpwm_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready
);

  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W = ((AW > svpwm_pkg::TIDX_W) ? AW : svpwm_pkg::TIDX_W) + 1;
  localparam logic [AW-1:0] MAX_ANGLE = AW'(TABLE_DEPTH - 1);
  localparam logic [svpwm_pkg::MUL_A_W-1:0] ANGLE_K =
    svpwm_pkg::MUL_A_W'(12 * TABLE_DEPTH);

  // ---------------------------------------------------------------- state
  svpwm_pkg::svpwm_state_e state_q, state_d;

  logic [svpwm_pkg::WORD_W-1:0]   period_q;
  logic [svpwm_pkg::MOD_W-1:0]    min_mod_q;
  logic [svpwm_pkg::LIM_W-1:0]    slew_lim_q;
  logic [svpwm_pkg::PER_W-1:0]    num_q;

  logic [svpwm_pkg::SAMPLE_W-1:0] follower_q, follower_d;
  logic [svpwm_pkg::SLEW_W-1:0]   slew_cnt_q, slew_cnt_d;
  logic                           moved_q, moved_d;
  logic [svpwm_pkg::MOD_W-1:0]    mod_q, mod_d;
  // Samples per period; the previous period always equals it between ticks.
  logic [svpwm_pkg::PER_W-1:0]    samples_q, samples_d;
  logic [svpwm_pkg::POS_W-1:0]    pos_q, pos_d;
  logic [svpwm_pkg::SEC_W-1:0]    sector_q, sector_d;
  logic                           out_valid_q, out_valid_d;
  logic [svpwm_pkg::CNT_W-1:0]    div_cnt_q, div_cnt_d;

  // payload
  logic [AW-1:0]                  angle_q, angle_d;
  logic [svpwm_pkg::WORD_W-1:0]   ta_q, ta_d, tb_q, tb_d;
  logic [svpwm_pkg::PER_W-1:0]    pnew_q, pnew_d;
  logic [svpwm_pkg::PROD_W-1:0]   prod_q;
  logic [svpwm_pkg::DEN_W-1:0]    div_rem_q, div_rem_d;
  logic [svpwm_pkg::DIV_W-1:0]    div_dq_q, div_dq_d;
  logic [svpwm_pkg::DEN_W-1:0]    div_den_q, div_den_d;
  logic [svpwm_pkg::WORD_W-1:0]   duty_a_q, duty_a_d, duty_b_q, duty_b_d, duty_c_q, duty_c_d;
  logic [svpwm_pkg::SEC_W-1:0]    sec_out_q, sec_out_d;

  // ---------------------------------------------------------------- config port
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      svpwm_pkg::REG_PWM_PERIOD: prdata = svpwm_pkg::PDATA_W'(period_q);
      svpwm_pkg::REG_MIN_MOD:    prdata = svpwm_pkg::PDATA_W'(min_mod_q);
      svpwm_pkg::REG_SLEW_LIMIT: prdata = svpwm_pkg::PDATA_W'(slew_lim_q);
      svpwm_pkg::REG_PERIOD_NUM: prdata = svpwm_pkg::PDATA_W'(num_q);
      default:                   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- sine table
  logic                in_acc;
  logic [IDX_W-1:0]    tidx_ext;
  logic                tbl_we;
  logic [AW-1:0]       tbl_raddr;
  logic [svpwm_pkg::WORD_W-1:0] tbl_rdata;

  assign in_stall_o = (state_q != svpwm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign tidx_ext   = IDX_W'(table_index_i);
  assign tbl_we     = in_acc && (cmd_i == svpwm_pkg::CMD_TABLE_WR) &&
                      (tidx_ext < IDX_W'(TABLE_DEPTH));

  svpwm_ram #(
    .WIDTH (svpwm_pkg::WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tidx_ext[AW-1:0]),
    .wdata_i (table_value_i),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  // ---------------------------------------------------------------- shared multiplier
  logic [svpwm_pkg::MUL_A_W-1:0] mul_a;
  logic [svpwm_pkg::MUL_B_W-1:0] mul_b;

  always_comb begin
    case (state_q)
      svpwm_pkg::ST_RD_TB, svpwm_pkg::ST_SCALE_TA: begin
        mul_a = svpwm_pkg::MUL_A_W'(mod_q);
        mul_b = svpwm_pkg::MUL_B_W'(tbl_rdata);
      end
      svpwm_pkg::ST_PSTORE: begin
        mul_a = div_dq_q[svpwm_pkg::PER_W-1:0];
        mul_b = pos_q;
      end
      default: begin
        mul_a = ANGLE_K;
        mul_b = pos_q;
      end
    endcase
  end

  // ---------------------------------------------------------------- serial divider step
  logic [svpwm_pkg::DEN_W:0]   div_shift;
  logic [svpwm_pkg::DEN_W+1:0] div_diff;
  logic                        div_last;

  assign div_shift = {div_rem_q, div_dq_q[svpwm_pkg::DIV_W-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, div_den_q};
  assign div_last  = (div_cnt_q == svpwm_pkg::CNT_W'(1));

  // ---------------------------------------------------------------- tick arithmetic
  logic [svpwm_pkg::WORD_W-1:0] t0, h;
  logic [svpwm_pkg::POS_W-1:0]  pos_inc;
  logic                         sec_wrap;
  logic [svpwm_pkg::SEC_W-1:0]  sec_inc;
  logic                         fire;

  assign t0      = period_q - ta_q - tb_q;
  assign h       = t0 >> 1;
  assign pos_inc = pos_q + svpwm_pkg::POS_W'(1);
  // pos + 1 >= floor(P/6) is the same as 6*(pos + 1) + 6 > P
  assign sec_wrap = ((svpwm_pkg::DEN_W'(pos_inc) * svpwm_pkg::DEN_W'(6)) + svpwm_pkg::DEN_W'(6))
                    > svpwm_pkg::DEN_W'(samples_q);
  assign sec_inc  = sec_wrap ? sector_q + svpwm_pkg::SEC_W'(1) : sector_q;
  assign fire     = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d     = state_q;
    follower_d  = follower_q;
    slew_cnt_d  = slew_cnt_q;
    moved_d     = moved_q;
    mod_d       = mod_q;
    samples_d   = samples_q;
    pos_d       = pos_q;
    sector_d    = sector_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_cnt_d   = div_cnt_q;
    angle_d     = angle_q;
    ta_d        = ta_q;
    tb_d        = tb_q;
    pnew_d      = pnew_q;
    div_rem_d   = div_rem_q;
    div_dq_d    = div_dq_q;
    div_den_d   = div_den_q;
    duty_a_d    = duty_a_q;
    duty_b_d    = duty_b_q;
    duty_c_d    = duty_c_q;
    sec_out_d   = sec_out_q;
    tbl_raddr   = angle_q;

    case (state_q)
      svpwm_pkg::ST_IDLE: begin
        if (in_acc && (cmd_i == svpwm_pkg::CMD_TICK)) begin
          moved_d = 1'b0;
          if (svpwm_pkg::SLEW_W'(slew_lim_q) >= slew_cnt_q) begin
            slew_cnt_d = slew_cnt_q + svpwm_pkg::SLEW_W'(1);
          end else if (follower_q != adc_sample_i) begin
            follower_d = (adc_sample_i > follower_q) ? follower_q + svpwm_pkg::SAMPLE_W'(1)
                                                     : follower_q - svpwm_pkg::SAMPLE_W'(1);
            moved_d    = 1'b1;
            slew_cnt_d = '0;
          end
          state_d = svpwm_pkg::ST_AMUL;
        end
      end
      svpwm_pkg::ST_AMUL: begin
        state_d = svpwm_pkg::ST_ADIV_LD;
      end
      svpwm_pkg::ST_ADIV_LD: begin
        if (samples_q == '0) begin
          angle_d = MAX_ANGLE;
          state_d = svpwm_pkg::ST_RD_TA;
        end else begin
          // round half up: (2*6*D*pos + P) / (2*P)
          div_dq_d  = prod_q + svpwm_pkg::DIV_W'(samples_q);
          div_den_d = {samples_q, 1'b0};
          div_rem_d = '0;
          div_cnt_d = svpwm_pkg::CNT_W'(svpwm_pkg::DIV_W);
          state_d   = svpwm_pkg::ST_ADIV;
        end
      end
      svpwm_pkg::ST_ADIV, svpwm_pkg::ST_PDIV, svpwm_pkg::ST_SDIV: begin
        if (!div_diff[svpwm_pkg::DEN_W+1]) begin
          div_rem_d = div_diff[svpwm_pkg::DEN_W-1:0];
          div_dq_d  = {div_dq_q[svpwm_pkg::DIV_W-2:0], 1'b1};
        end else begin
          div_rem_d = div_shift[svpwm_pkg::DEN_W-1:0];
          div_dq_d  = {div_dq_q[svpwm_pkg::DIV_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q - svpwm_pkg::CNT_W'(1);
        if (div_last) begin
          case (state_q)
            svpwm_pkg::ST_ADIV: state_d = svpwm_pkg::ST_ACLAMP;
            svpwm_pkg::ST_PDIV: state_d = svpwm_pkg::ST_PSTORE;
            default:            state_d = svpwm_pkg::ST_SSTORE;
          endcase
        end
      end
      svpwm_pkg::ST_ACLAMP: begin
        angle_d = (div_dq_q > svpwm_pkg::DIV_W'(MAX_ANGLE)) ? MAX_ANGLE : div_dq_q[AW-1:0];
        state_d = svpwm_pkg::ST_RD_TA;
      end
      svpwm_pkg::ST_RD_TA: begin
        tbl_raddr = MAX_ANGLE - angle_q;
        state_d   = svpwm_pkg::ST_RD_TB;
      end
      svpwm_pkg::ST_RD_TB: begin
        state_d = svpwm_pkg::ST_SCALE_TA;
      end
      svpwm_pkg::ST_SCALE_TA: begin
        ta_d    = prod_q[svpwm_pkg::WORD_W+11:12];
        state_d = svpwm_pkg::ST_SCALE_TB;
      end
      svpwm_pkg::ST_SCALE_TB: begin
        tb_d    = prod_q[svpwm_pkg::WORD_W+11:12];
        state_d = svpwm_pkg::ST_DUTY;
      end
      svpwm_pkg::ST_DUTY: begin
        // hold until the previous result has been taken
        if (fire) begin
          out_valid_d = 1'b1;
          sec_out_d   = sector_q;
          case (sector_q)
            3'd1: begin
              duty_a_d = ta_q + h; duty_b_d = ta_q + tb_q + h; duty_c_d = h;
            end
            3'd2: begin
              duty_a_d = h; duty_b_d = ta_q + tb_q + h; duty_c_d = tb_q + h;
            end
            3'd3: begin
              duty_a_d = h; duty_b_d = ta_q + h; duty_c_d = ta_q + tb_q + h;
            end
            3'd4: begin
              duty_a_d = tb_q + h; duty_b_d = h; duty_c_d = ta_q + tb_q + h;
            end
            3'd5: begin
              duty_a_d = ta_q + tb_q + h; duty_b_d = h; duty_c_d = ta_q + h;
            end
            default: begin
              duty_a_d = ta_q + tb_q + h; duty_b_d = tb_q + h; duty_c_d = h;
            end
          endcase
          pos_d    = sec_wrap ? '0 : pos_inc;
          sector_d = (sec_inc > svpwm_pkg::LAST_SECTOR) ? '0 : sec_inc;
          state_d  = moved_q ? svpwm_pkg::ST_RC : svpwm_pkg::ST_IDLE;
        end
      end
      svpwm_pkg::ST_RC: begin
        mod_d      = (svpwm_pkg::MOD_W'(follower_q) < min_mod_q) ? min_mod_q
                                                                 : svpwm_pkg::MOD_W'(follower_q);
        follower_d = (follower_q == '0) ? svpwm_pkg::SAMPLE_W'(1) : follower_q;
        div_dq_d   = svpwm_pkg::DIV_W'(num_q);
        div_den_d  = svpwm_pkg::DEN_W'(follower_d);
        div_rem_d  = '0;
        div_cnt_d  = svpwm_pkg::CNT_W'(svpwm_pkg::DIV_W);
        state_d    = svpwm_pkg::ST_PDIV;
      end
      svpwm_pkg::ST_PSTORE: begin
        pnew_d = div_dq_q[svpwm_pkg::PER_W-1:0];
        if (samples_q == '0) begin
          pos_d     = '0;
          samples_d = div_dq_q[svpwm_pkg::PER_W-1:0];
          state_d   = svpwm_pkg::ST_IDLE;
        end else begin
          state_d = svpwm_pkg::ST_SMUL;
        end
      end
      svpwm_pkg::ST_SMUL: begin
        // rescale position: P_new * pos / P_old
        div_dq_d  = prod_q;
        div_den_d = svpwm_pkg::DEN_W'(samples_q);
        div_rem_d = '0;
        div_cnt_d = svpwm_pkg::CNT_W'(svpwm_pkg::DIV_W);
        state_d   = svpwm_pkg::ST_SDIV;
      end
      svpwm_pkg::ST_SSTORE: begin
        pos_d     = div_dq_q[svpwm_pkg::POS_W-1:0];
        samples_d = pnew_q;
        state_d   = svpwm_pkg::ST_IDLE;
      end
      default: begin
        state_d = svpwm_pkg::ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= svpwm_pkg::ST_IDLE;
      period_q    <= svpwm_pkg::PWM_PERIOD_RST;
      min_mod_q   <= svpwm_pkg::MIN_MOD_RST;
      slew_lim_q  <= svpwm_pkg::SLEW_LIMIT_RST;
      num_q       <= svpwm_pkg::PERIOD_NUM_RST;
      follower_q  <= '0;
      slew_cnt_q  <= '0;
      moved_q     <= 1'b0;
      mod_q       <= svpwm_pkg::MOD_INDEX_RST;
      samples_q   <= svpwm_pkg::SAMPLES_RST;
      pos_q       <= '0;
      sector_q    <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      follower_q  <= follower_d;
      slew_cnt_q  <= slew_cnt_d;
      moved_q     <= moved_d;
      mod_q       <= mod_d;
      samples_q   <= samples_d;
      pos_q       <= pos_d;
      sector_q    <= sector_d;
      out_valid_q <= out_valid_d;
      div_cnt_q   <= div_cnt_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          svpwm_pkg::REG_PWM_PERIOD: period_q   <= pwdata[svpwm_pkg::WORD_W-1:0];
          svpwm_pkg::REG_MIN_MOD:    min_mod_q  <= pwdata[svpwm_pkg::MOD_W-1:0];
          svpwm_pkg::REG_SLEW_LIMIT: slew_lim_q <= pwdata[svpwm_pkg::LIM_W-1:0];
          svpwm_pkg::REG_PERIOD_NUM: num_q      <= pwdata[svpwm_pkg::PER_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= mul_a * mul_b;
    angle_q   <= angle_d;
    ta_q      <= ta_d;
    tb_q      <= tb_d;
    pnew_q    <= pnew_d;
    div_rem_q <= div_rem_d;
    div_dq_q  <= div_dq_d;
    div_den_q <= div_den_d;
    duty_a_q  <= duty_a_d;
    duty_b_q  <= duty_b_d;
    duty_c_q  <= duty_c_d;
    sec_out_q <= sec_out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign duty_a_o      = duty_a_q;
  assign duty_b_o      = duty_b_q;
  assign duty_c_o      = duty_c_q;
  assign sector_used_o = sec_out_q;

  // ---------------------------------------------------------------- assertions
  a_angle_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svpwm_pkg::ST_RD_TA) |-> (angle_q <= MAX_ANGLE))
    else $error("table angle beyond last entry");

  a_sector_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sector_q <= svpwm_pkg::LAST_SECTOR)
    else $error("sector out of range");

  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == svpwm_pkg::ST_ADIV || state_q == svpwm_pkg::ST_PDIV ||
     state_q == svpwm_pkg::ST_SDIV) |-> (div_rem_q < div_den_q))
    else $error("divider remainder not below divisor");

  a_result_from_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !($past(out_valid_q) && $past(out_stall_i))) |->
      ($past(state_q) == svpwm_pkg::ST_DUTY))
    else $error("result item not produced by the duty step");

  a_follower_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (follower_q == $past(follower_q)) ||
    (follower_q == $past(follower_q) + svpwm_pkg::SAMPLE_W'(1)) ||
    (follower_q == $past(follower_q) - svpwm_pkg::SAMPLE_W'(1)))
    else $error("speed follower moved more than one step");

endmodule
